// ----- design/fbcs_pkg.sv -----
// ----------------------------------------------------------------------------
// fbcs_pkg
// Shared types, constants and helper functions of the falling box collision
// step block.
// ----------------------------------------------------------------------------
package fbcs_pkg;

  localparam int MAX_BOXES = 64;
  localparam int IDX_W     = $clog2(MAX_BOXES);
  localparam int CNT_W     = IDX_W + 1;

  localparam logic [23:0] GRAVITY_RESET = 24'd642253;
  localparam logic [31:0] FLOOR_RESET   = 32'hFE0C_0000;

  typedef enum logic [1:0] {
    CFG_GRAVITY = 2'd0,
    CFG_FLOOR   = 2'd1
  } cfg_index_e;

  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_FULL  = 2'd1,
    ST_BOX   = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD_I,
    S_MUL,
    S_SAT,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_e;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [23:0] size_x;
    logic        [23:0] size_y;
    logic        [23:0] size_z;
    logic        [15:0] time_step;
  } in_beat_t;

  typedef struct packed {
    status_e            status;
    logic [IDX_W-1:0]   box_index;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_velocity;
    logic               collided;
    logic               last;
  } out_beat_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic        [23:0] sx;
    logic        [23:0] sy;
    logic        [23:0] sz;
    logic signed [31:0] v;
  } box_t;

  typedef struct packed {
    logic    load;
    logic    rd_i;
    logic    mul;
    logic    sat;
    logic    scan;
    logic    emit;
    status_e kind;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic full;
    logic empty;
    logic below;
    logic j_last;
    logic i_last;
    logic out_free;
  } dp_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic apart(input logic signed [31:0] amin, input logic [23:0] asz,
                                 input logic signed [31:0] bmin, input logic [23:0] bsz);
    logic signed [33:0] amax;
    logic signed [33:0] bmax;
    logic signed [33:0] a0;
    logic signed [33:0] b0;
    a0   = {{2{amin[31]}}, amin};
    b0   = {{2{bmin[31]}}, bmin};
    amax = a0 + $signed({10'b0, asz});
    bmax = b0 + $signed({10'b0, bsz});
    return (amax <= b0) || (a0 >= bmax);
  endfunction

endpackage

// ----- design/fbcs_ctrl.sv -----
// ----------------------------------------------------------------------------
// fbcs_ctrl
// Sequencer: decodes each input beat and steps the datapath through the add,
// the per-box update and the overlap scan.
// ----------------------------------------------------------------------------
module fbcs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fbcs_pkg::dp_status_t sts_i,
  output fbcs_pkg::ctl_cmd_t   cmd_o
);
  import fbcs_pkg::*;

  state_e  state_q, state_d;
  status_e kind_q, kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= ST_ADDED;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    cmd_o      = '0;
    cmd_o.kind = kind_q;
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts_i.is_tick) begin
          kind_d  = sts_i.full ? ST_FULL : ST_ADDED;
          state_d = S_EMIT;
        end else if (sts_i.empty) begin
          kind_d  = ST_EMPTY;
          state_d = S_EMIT;
        end else begin
          kind_d  = ST_BOX;
          state_d = S_RD_I;
        end
      end
      S_RD_I: begin
        cmd_o.rd_i = 1'b1;
        state_d    = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SAT;
      end
      S_SAT: begin
        cmd_o.sat = 1'b1;
        state_d   = sts_i.below ? S_EMIT : S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.j_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (kind_q == ST_BOX && !sts_i.i_last) begin
            state_d = S_RD_I;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- design/fbcs_datapath.sv -----
// ----------------------------------------------------------------------------
// fbcs_datapath
// Box table memory, configuration registers, Euler step arithmetic, overlap
// test and the output register.
// ----------------------------------------------------------------------------
module fbcs_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fbcs_pkg::in_beat_t   in_data_i,
  input  logic                 cfg_valid_i,
  input  fbcs_pkg::cfg_index_e cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  fbcs_pkg::ctl_cmd_t   cmd_i,
  output fbcs_pkg::dp_status_t sts_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fbcs_pkg::out_beat_t  out_data_o
);
  import fbcs_pkg::*;

  box_t               mem_q [MAX_BOXES];
  box_t               rd_a_q, rd_b_q, cur_q;
  in_beat_t           in_q;
  logic [23:0]        gravity_q;
  logic signed [31:0] floor_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [IDX_W-1:0]   i_q, j_q, pj_q;
  logic               pend_q, hit_q, below_q, out_valid_q;
  logic signed [48:0] prod_v_q;
  logic [39:0]        prod_g_q;
  logic signed [31:0] new_y_q, new_v_q;
  out_beat_t          out_q;
  out_beat_t          out_d;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  box_t               mem_wdata;
  box_t               cur_new;
  logic               ovl;
  logic signed [31:0] y_fin, v_fin;
  logic               out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cur_new   = cur_q;
    cur_new.y = new_y_q;
    ovl = !apart(cur_new.x, cur_new.sx, rd_b_q.x, rd_b_q.sx) &&
          !apart(cur_new.y, cur_new.sy, rd_b_q.y, rd_b_q.sy) &&
          !apart(cur_new.z, cur_new.sz, rd_b_q.z, rd_b_q.sz);
    y_fin = (below_q || hit_q) ? cur_q.y : new_y_q;
    v_fin = below_q ? cur_q.v : new_v_q;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = i_q;
    mem_wdata = cur_q;
    if (cmd_i.emit && cmd_i.kind == ST_ADDED) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_q[IDX_W-1:0];
      mem_wdata = '{x: in_q.pos_x, y: in_q.pos_y, z: in_q.pos_z, sx: in_q.size_x,
                    sy: in_q.size_y, sz: in_q.size_z, v: 32'sd0};
    end else if (cmd_i.emit && cmd_i.kind == ST_BOX) begin
      mem_we      = 1'b1;
      mem_wdata.y = y_fin;
      mem_wdata.v = v_fin;
    end
  end

  always_comb begin
    out_d      = '0;
    out_d.last = 1'b1;
    unique case (cmd_i.kind)
      ST_ADDED: begin
        out_d.status    = ST_ADDED;
        out_d.box_index = cnt_q[IDX_W-1:0];
        out_d.out_x     = in_q.pos_x;
        out_d.out_y     = in_q.pos_y;
        out_d.out_z     = in_q.pos_z;
      end
      ST_FULL:  out_d.status = ST_FULL;
      ST_EMPTY: out_d.status = ST_EMPTY;
      ST_BOX: begin
        out_d.status       = ST_BOX;
        out_d.box_index    = i_q;
        out_d.out_x        = cur_q.x;
        out_d.out_y        = y_fin;
        out_d.out_z        = cur_q.z;
        out_d.out_velocity = v_fin;
        out_d.collided     = hit_q && !below_q;
        out_d.last         = sts_o.i_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.rd_i) begin
      rd_a_q <= mem_q[i_q];
    end
    if (cmd_i.scan) begin
      rd_b_q <= mem_q[j_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_data_i;
    end
    if (cmd_i.mul) begin
      cur_q    <= rd_a_q;
      prod_v_q <= rd_a_q.v * $signed({1'b0, in_q.time_step});
      prod_g_q <= gravity_q * in_q.time_step;
    end
    if (cmd_i.sat) begin
      new_y_q <= sat32({{2{cur_q.y[31]}}, cur_q.y} + {{1{prod_v_q[48]}}, prod_v_q[48:16]});
      new_v_q <= sat32({{2{cur_q.v[31]}}, cur_q.v} - $signed({10'b0, prod_g_q[39:16]}));
    end
    if (cmd_i.scan) begin
      pj_q <= j_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q   <= GRAVITY_RESET;
      floor_q     <= FLOOR_RESET;
      cnt_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      below_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_GRAVITY: gravity_q <= cfg_data_i[23:0];
          CFG_FLOOR:   floor_q   <= cfg_data_i;
          default:     ;
        endcase
      end
      if (cmd_i.load) begin
        i_q <= '0;
      end
      if (cmd_i.mul) begin
        below_q <= rd_a_q.y < floor_q;
      end
      if (cmd_i.sat) begin
        j_q   <= '0;
        hit_q <= 1'b0;
      end
      if (cmd_i.scan) begin
        j_q <= j_q + 1'b1;
      end
      pend_q <= cmd_i.scan;
      if (pend_q && pj_q != i_q && ovl) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        out_q       <= out_d;
        if (cmd_i.kind == ST_ADDED) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (cmd_i.kind == ST_BOX) begin
          i_q <= i_q + 1'b1;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.is_tick  = (in_q.cmd == CMD_TICK);
    sts_o.full     = cnt_q[CNT_W-1];
    sts_o.empty    = (cnt_q == '0);
    sts_o.below    = below_q;
    sts_o.j_last   = ({1'b0, j_q} + 1'b1) == cnt_q;
    sts_o.i_last   = ({1'b0, i_q} + 1'b1) == cnt_q;
    sts_o.out_free = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- design/falling_box_collision_step.sv -----
// ----------------------------------------------------------------------------
// falling_box_collision_step
// Table of falling axis-aligned boxes with an Euler step and overlap undo.
// ----------------------------------------------------------------------------
// Input beats arrive on in_valid_i/in_data_i and are taken when in_stall_o is
// low. An add beat appends one box unless the table is full, and returns one
// result beat. A tick beat returns one result beat per stored box, in slot
// order, with last set on the final one; a tick on an empty table returns one
// beat. An add or an empty tick passes the decode and emit states before its
// result is loaded; the next beat is taken once the sequencer is idle again.
// Each box above the floor is checked by the overlap scan, which reads one box
// from the table memory per cycle, its own slot included; a box below the floor
// skips the scan. The block takes one input beat at a time.
// Result beats sit in an output register; while out_stall_i is high the beat
// holds and the sequencer waits before producing the next one.
// Configuration writes on cfg_valid_i/cfg_index_i/cfg_data_i are always
// ready and belong only to idle periods.
// Reset empties the table and restores gravity 9.8 and floor level -500.
// ----------------------------------------------------------------------------
module falling_box_collision_step (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  fbcs_pkg::in_beat_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fbcs_pkg::out_beat_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  fbcs_pkg::cfg_index_e cfg_index_i,
  input  logic [31:0]          cfg_data_i
);
  import fbcs_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t sts;

  assign cfg_ready_o = 1'b1;

  fbcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fbcs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- design/fbcs_checker.sv -----
// ----------------------------------------------------------------------------
// fbcs_checker
// Port-level checks of the falling box collision step block.
// ----------------------------------------------------------------------------
module fbcs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input fbcs_pkg::out_beat_t out_data_o
);
  import fbcs_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a beat is in progress");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_BOX |-> out_data_o.last)
    else $error("single result beat without last");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_FULL || out_data_o.status == ST_EMPTY)
    |-> out_data_o.box_index == '0 && !out_data_o.collided)
    else $error("full or empty beat carries box data");

endmodule

bind falling_box_collision_step fbcs_checker u_fbcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ----- tb/falling_box_collision_step_tb.sv -----
// ----------------------------------------------------------------------------
// falling_box_collision_step_tb
// Self-checking testbench of the falling box collision step block.
// An in-line model of the box table predicts every result beat of each
// accepted command. Directed tests cover an empty tick, extreme corners and
// sizes, touching faces, overlap undo and boxes below the floor. Random
// phases then fill the table past its limit under several register settings
// and several patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module falling_box_collision_step_tb;
  import fbcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam logic        [23:0] SIZE_ONE = 24'h01_0000;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_beat_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_beat_t           out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  cfg_index_e          cfg_index_i = CFG_GRAVITY;
  logic [31:0]         cfg_data_i  = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;

  out_beat_t pending_beats[$];

  logic        [23:0] gravity_reg;
  logic signed [31:0] floor_reg;
  logic signed [31:0] box_x[MAX_BOXES];
  logic signed [31:0] box_y[MAX_BOXES];
  logic signed [31:0] box_z[MAX_BOXES];
  logic        [23:0] box_sx[MAX_BOXES];
  logic        [23:0] box_sy[MAX_BOXES];
  logic        [23:0] box_sz[MAX_BOXES];
  logic signed [31:0] box_vel[MAX_BOXES];
  int unsigned        box_total;

  falling_box_collision_step uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic logic signed [31:0] clamp32(input longint v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic separated(input longint amin, input longint asz,
                                     input longint bmin, input longint bsz);
    return (amin + asz <= bmin) || (amin >= bmin + bsz);
  endfunction

  function automatic logic boxes_overlap(input int unsigned a, input int unsigned b);
    if (separated(box_x[a], box_sx[a], box_x[b], box_sx[b])) return 1'b0;
    if (separated(box_y[a], box_sy[a], box_y[b], box_sy[b])) return 1'b0;
    if (separated(box_z[a], box_sz[a], box_z[b], box_sz[b])) return 1'b0;
    return 1'b1;
  endfunction

  task automatic predict_step(input in_beat_t b);
    out_beat_t          r;
    longint             dt;
    longint             vel;
    logic signed [31:0] old_y;
    logic               hit;
    r = '0;
    r.last = 1'b1;
    if (b.cmd == CMD_ADD) begin
      if (box_total >= MAX_BOXES) begin
        r.status = ST_FULL;
      end else begin
        box_x[box_total]   = b.pos_x;
        box_y[box_total]   = b.pos_y;
        box_z[box_total]   = b.pos_z;
        box_sx[box_total]  = b.size_x;
        box_sy[box_total]  = b.size_y;
        box_sz[box_total]  = b.size_z;
        box_vel[box_total] = '0;
        r.status    = ST_ADDED;
        r.box_index = box_total[IDX_W-1:0];
        r.out_x     = b.pos_x;
        r.out_y     = b.pos_y;
        r.out_z     = b.pos_z;
        box_total++;
      end
      pending_beats.insert(pending_beats.size(), r);
    end else if (box_total == 0) begin
      r.status = ST_EMPTY;
      pending_beats.insert(pending_beats.size(), r);
    end else begin
      dt = longint'(b.time_step);
      for (int unsigned i = 0; i < box_total; i++) begin
        hit = 1'b0;
        if (box_y[i] >= floor_reg) begin
          old_y      = box_y[i];
          vel        = box_vel[i];
          box_y[i]   = clamp32(longint'(old_y) + ((vel * dt) >>> 16));
          box_vel[i] = clamp32(vel - ((longint'(gravity_reg) * dt) >>> 16));
          for (int unsigned j = 0; j < box_total; j++) begin
            if (j != i && boxes_overlap(i, j)) hit = 1'b1;
          end
          if (hit) box_y[i] = old_y;
        end
        r.status       = ST_BOX;
        r.box_index    = i[IDX_W-1:0];
        r.out_x        = box_x[i];
        r.out_y        = box_y[i];
        r.out_z        = box_z[i];
        r.out_velocity = box_vel[i];
        r.collided     = hit;
        r.last         = (i + 1 == box_total);
        pending_beats.insert(pending_beats.size(), r);
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected result beat status %0d", out_data_o.status);
        error_count++;
      end else begin
        want = pending_beats.pop_front();
        if (out_data_o.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_data_o.status);
          error_count++;
        end
        if (out_data_o.box_index !== want.box_index) begin
          $error("box_index expected %0d actual %0d", want.box_index, out_data_o.box_index);
          error_count++;
        end
        if (out_data_o.out_x !== want.out_x) begin
          $error("out_x expected %0d actual %0d", want.out_x, out_data_o.out_x);
          error_count++;
        end
        if (out_data_o.out_y !== want.out_y) begin
          $error("out_y expected %0d actual %0d", want.out_y, out_data_o.out_y);
          error_count++;
        end
        if (out_data_o.out_z !== want.out_z) begin
          $error("out_z expected %0d actual %0d", want.out_z, out_data_o.out_z);
          error_count++;
        end
        if (out_data_o.out_velocity !== want.out_velocity) begin
          $error("out_velocity expected %0d actual %0d", want.out_velocity,
                 out_data_o.out_velocity);
          error_count++;
        end
        if (out_data_o.collided !== want.collided) begin
          $error("collided expected %0d actual %0d", want.collided, out_data_o.collided);
          error_count++;
        end
        if (out_data_o.last !== want.last) begin
          $error("last expected %0d actual %0d", want.last, out_data_o.last);
          error_count++;
        end
      end
    end
  end

  task automatic send_beat(input in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    predict_step(b);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_index_e idx, input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_GRAVITY) gravity_reg = value[23:0];
    else if (idx == CFG_FLOOR) floor_reg = value;
  endtask

  function automatic in_beat_t make_add(input logic signed [31:0] x, input logic signed [31:0] y,
                                        input logic signed [31:0] z, input logic [23:0] sx,
                                        input logic [23:0] sy, input logic [23:0] sz);
    in_beat_t b;
    b = '0;
    b.cmd = CMD_ADD; b.pos_x = x; b.pos_y = y; b.pos_z = z;
    b.size_x = sx; b.size_y = sy; b.size_z = sz;
    b.time_step = 16'($urandom());
    return b;
  endfunction

  function automatic in_beat_t make_tick(input logic [15:0] dt);
    in_beat_t b;
    b = '0;
    b.cmd = CMD_TICK; b.pos_x = $urandom(); b.pos_y = $urandom(); b.pos_z = $urandom();
    b.size_x = 24'($urandom()); b.size_y = 24'($urandom()); b.size_z = 24'($urandom());
    b.time_step = dt;
    return b;
  endfunction

  function automatic in_beat_t make_random(input int unsigned add_pct);
    logic signed [31:0] x, y, z;
    if ($urandom_range(99) >= add_pct) begin
      unique case ($urandom_range(3))
        0:       return make_tick(16'h0000);
        1:       return make_tick(16'hFFFF);
        default: return make_tick(16'($urandom()));
      endcase
    end
    if ($urandom_range(4) == 0) begin
      return make_add($urandom(), $urandom(), $urandom(), 24'($urandom()), 24'($urandom()),
                      24'($urandom()));
    end
    x = $signed($urandom_range(40 * ONE)) - 20 * ONE;
    y = $signed($urandom_range(40 * ONE)) - 20 * ONE;
    z = $signed($urandom_range(40 * ONE)) - 20 * ONE;
    return make_add(x, y, z, 24'($urandom_range(4 * ONE)), 24'($urandom_range(4 * ONE)),
                    24'($urandom_range(4 * ONE)));
  endfunction

  task automatic test_empty_tick();
    send_beat(make_tick(16'h8000));
    drain_results();
  endtask

  task automatic test_extreme_boxes();
    send_beat(make_add(32'sd0, 32'sd0, 32'sd0, SIZE_ONE, SIZE_ONE, SIZE_ONE));
    send_beat(make_add(ONE, 32'sd0, 32'sd0, SIZE_ONE, SIZE_ONE, SIZE_ONE));
    send_beat(make_add(ONE / 2, ONE / 2, 32'sd0, SIZE_ONE, SIZE_ONE, SIZE_ONE));
    send_beat(make_add(32'sd0, 3 * ONE, 32'sd0, SIZE_ONE, SIZE_ONE, SIZE_ONE));
    send_beat(make_add(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                       24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
    send_beat(make_add(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                       24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
    send_beat(make_add(5 * ONE, -600 * ONE, 32'sd0, 24'd0, 24'd0, 24'd0));
    drain_results();
  endtask

  task automatic test_falling_motion();
    send_beat(make_tick(16'h0000));
    send_beat(make_tick(16'h2000));
    send_beat(make_tick(16'h4000));
    send_beat(make_tick(16'hFFFF));
    send_beat(make_tick(16'h1000));
    drain_results();
  endtask

  task automatic test_register_settings();
    write_register(CFG_GRAVITY, 32'h00FF_FFFF);
    write_register(CFG_FLOOR, 32'h8000_0000);
    send_beat(make_tick(16'hFFFF));
    send_beat(make_tick(16'hFFFF));
    drain_results();
    write_register(CFG_GRAVITY, 32'h0000_0000);
    write_register(CFG_FLOOR, 32'h7FFF_FFFF);
    write_register(cfg_index_e'(2'd2), 32'hFFFF_FFFF);
    write_register(cfg_index_e'(2'd3), 32'h1234_5678);
    send_beat(make_tick(16'hFFFF));
    drain_results();
  endtask

  task automatic test_random_phase(input int unsigned items, input int unsigned add_pct);
    for (int unsigned k = 0; k < items; k++) send_beat(make_random(add_pct));
    drain_results();
  endtask

  task automatic test_random_traffic();
    write_register(CFG_GRAVITY, {8'h00, GRAVITY_RESET});
    write_register(CFG_FLOOR, FLOOR_RESET);
    send_idle_pct = 12;
    recv_idle_pct = 77;
    test_random_phase(45, 80);
    write_register(CFG_GRAVITY, 32'h00FF_FFFF);
    write_register(CFG_FLOOR, 32'h8000_0000);
    send_idle_pct = 77;
    recv_idle_pct = 12;
    test_random_phase(40, 55);
    write_register(CFG_GRAVITY, $urandom());
    write_register(CFG_FLOOR, $signed($urandom_range(20 * ONE)) - 10 * ONE);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_phase(40, 40);
  endtask

  initial begin
    gravity_reg = GRAVITY_RESET;
    floor_reg   = FLOOR_RESET;
    box_total   = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 12;
    recv_idle_pct = 77;
    test_empty_tick();
    test_extreme_boxes();
    test_falling_motion();
    test_register_settings();
    test_random_traffic();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- falling_box_collision_step.f -----
design/fbcs_pkg.sv
design/fbcs_ctrl.sv
design/fbcs_datapath.sv
design/falling_box_collision_step.sv
design/fbcs_checker.sv
tb/falling_box_collision_step_tb.sv
